// ----- hw/rtl/rgb_led_pulse_encoder_breath_core_defines.svh -----
// ----------------------------------------------------------------------------
// RGB LED pulse encoder assertion macros
// Shared property shapes for the checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PULSE_ENCODER_BREATH_CORE_DEFINES_SVH
`define RGB_LED_PULSE_ENCODER_BREATH_CORE_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define RLPE_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define RLPE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hw/rtl/rlpe_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB LED pulse encoder package
// Widths, codes, symbol timings and shared helpers.
// ----------------------------------------------------------------------------
package rlpe_pkg;

   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 3 * CHAN_W;
   localparam int PERIOD_W   = 16;
   localparam int ELAPSED_W  = 32;
   localparam int TICKS_W    = 15;
   localparam int REQ_TYPE_W = 2;
   localparam int PROD_W     = CHAN_W + PERIOD_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [REQ_TYPE_W-1:0] REQ_SET     = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_REFRESH = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR   = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_BREATH  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MASTER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK   = 2'd3;

   localparam logic [CHAN_W-1:0]   MASTER_RESET = 8'd255;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2000;
   localparam logic [CHAN_W-1:0]   FLOOR_RESET  = 8'd0;
   localparam logic [CHAN_W-1:0]   PEAK_RESET   = 8'd255;
   localparam logic [COLOR_W-1:0]  COLOR_RESET  = 24'h0000FF;

   localparam logic [TICKS_W-1:0] ONE_HIGH    = 15'd8;
   localparam logic [TICKS_W-1:0] ONE_LOW     = 15'd4;
   localparam logic [TICKS_W-1:0] ZERO_HIGH   = 15'd4;
   localparam logic [TICKS_W-1:0] ZERO_LOW    = 15'd8;
   localparam logic [TICKS_W-1:0] RESET_TICKS = 15'd600;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_RAMP_MUL,
      ST_RAMP_DIV,
      ST_EFF_MUL,
      ST_CHAN,
      ST_SEND
   } rlpe_state_type;

   // Exact floor(p / 255) for any 16-bit product of two 8-bit values.
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
      logic [2*CHAN_W:0] t;
      t = {1'b0, p} + {{(2*CHAN_W){1'b0}}, 1'b1} + {{(CHAN_W+1){1'b0}}, p[2*CHAN_W-1:CHAN_W]};
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

// ----- hw/rtl/rlpe_if.sv -----
// ----------------------------------------------------------------------------
// RGB LED pulse encoder channels
// Request and symbol channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rlpe_req_if;
   import rlpe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CHAN_W-1:0]     red_in;
   logic [CHAN_W-1:0]     green_in;
   logic [CHAN_W-1:0]     blue_in;
   logic [ELAPSED_W-1:0]  millis_in;

   modport source (output valid, req_type, red_in, green_in, blue_in, millis_in,
                   input ready);
   modport sink   (input valid, req_type, red_in, green_in, blue_in, millis_in,
                   output ready);
endinterface

interface rlpe_rsp_if;
   import rlpe_pkg::*;
   logic               valid;
   logic               ready;
   logic               first_level;
   logic [TICKS_W-1:0] first_ticks;
   logic [TICKS_W-1:0] second_ticks;
   logic               last_symbol;

   modport source (output valid, first_level, first_ticks, second_ticks, last_symbol,
                   input ready);
   modport sink   (input valid, first_level, first_ticks, second_ticks, last_symbol,
                   output ready);
endinterface

// ----- hw/rtl/rlpe_serial_div.sv -----
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module rlpe_serial_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rlpe_pkg::ELAPSED_W-1:0]  dividend,
   input  logic [rlpe_pkg::PERIOD_W-1:0]   divisor,
   output logic                            done,
   output logic [rlpe_pkg::ELAPSED_W-1:0]  quotient,
   output logic [rlpe_pkg::PERIOD_W-1:0]   remainder
);
   import rlpe_pkg::*;

   localparam int CNT_W = $clog2(ELAPSED_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ELAPSED_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ELAPSED_W-1:0] quo_ff, quo_in;
   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [PERIOD_W-1:0]  dvs_ff, dvs_in;
   logic [PERIOD_W:0]    trial;
   logic [PERIOD_W:0]    diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[ELAPSED_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ELAPSED_W-2:0], fits};
         rem_in = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/rlpe_serial_mul.sv -----
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add product of an 8-bit and a 16-bit operand, MSB first.
// ----------------------------------------------------------------------------
module rlpe_serial_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rlpe_pkg::CHAN_W-1:0]   mult_a,
   input  logic [rlpe_pkg::PERIOD_W-1:0] mult_b,
   output logic                          done,
   output logic [rlpe_pkg::PROD_W-1:0]   product
);
   import rlpe_pkg::*;

   localparam int CNT_W = $clog2(CHAN_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CHAN_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CHAN_W-1:0]   a_ff, a_in;
   logic [PERIOD_W-1:0] b_ff, b_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mult_a;
         b_in    = mult_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                + (a_ff[CHAN_W-1] ? {{CHAN_W{1'b0}}, b_ff} : {PROD_W{1'b0}});
         a_in   = {a_ff[CHAN_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- hw/rtl/rlpe_symbol_tx.sv -----
// ----------------------------------------------------------------------------
// Pulse symbol transmitter
// Shifts a GRB word out as 24 data symbols and one reset symbol.
// ----------------------------------------------------------------------------
module rlpe_symbol_tx (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rlpe_pkg::COLOR_W-1:0] grb,
   output logic                         done,
   rlpe_rsp_if.source                   rsp
);
   import rlpe_pkg::*;

   localparam int CNT_W = $clog2(COLOR_W + 1);
   localparam logic [CNT_W-1:0] RESET_SLOT = CNT_W'(COLOR_W);

   logic                valid_ff, valid_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [COLOR_W-1:0]  shift_ff, shift_in;
   logic                take;
   logic                is_reset;
   logic                bit_now;

   assign take     = valid_ff && rsp.ready;
   assign is_reset = cnt_ff == RESET_SLOT;
   assign bit_now  = shift_ff[COLOR_W-1];

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (start) begin
         valid_in = 1'b1;
         cnt_in   = '0;
         shift_in = grb;
      end else if (take) begin
         if (is_reset) begin
            valid_in = 1'b0;
         end else begin
            cnt_in   = cnt_ff + 1'b1;
            shift_in = {shift_ff[COLOR_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.first_level  = !is_reset;
   assign rsp.first_ticks  = is_reset ? RESET_TICKS : (bit_now ? ONE_HIGH : ZERO_HIGH);
   assign rsp.second_ticks = is_reset ? {TICKS_W{1'b0}} : (bit_now ? ONE_LOW : ZERO_LOW);
   assign rsp.last_symbol  = is_reset;
   assign done             = take && is_reset;

endmodule

// ----- hw/rtl/rgb_led_pulse_encoder_breath_core.sv -----
// ----------------------------------------------------------------------------
// RGB LED pulse encoder with breath effect
// Turns colour requests into frames of pulse symbols for one LED.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel, one transaction per request, and
// are taken only while the core is idle. Each accepted request (except a
// breath step while the period is below two, which is dropped silently)
// yields one frame of 25 transactions on the rsp channel: 24 data symbols in
// green, red, blue order, most significant bit first, then one reset symbol
// flagged by last_symbol. The csr port writes brightness and breath settings
// and should only be used while the core is idle.
// Operation. All arithmetic runs through one bit-serial multiplier and one
// bit-serial divider. A set or refresh request scales three channels before
// its first symbol is offered, a clear request sends an all-zero frame with
// no arithmetic, and a breath step first runs a modulo, a ramp product and
// quotient and the brightness product, then scales the three channels.
// Symbols then leave at one per cycle while rsp.ready is high, and a new
// request is taken the cycle after the reset symbol has gone. Stalling rsp
// simply holds the current symbol and keeps req.ready low.
// Reset restores the register defaults and a stored colour of pure blue.
// ----------------------------------------------------------------------------
`include "rgb_led_pulse_encoder_breath_core_defines.svh"

module rgb_led_pulse_encoder_breath_core (
   input  logic                            clock,
   input  logic                            reset,
   rlpe_req_if.sink                        req,
   rlpe_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [rlpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlpe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rlpe_pkg::*;

   localparam logic [1:0] CH_LAST = 2'd2;

   // Control state and configuration.
   rlpe_state_type      state_ff, state_in;
   logic                kick_ff, kick_in;
   logic [1:0]          ch_ff, ch_in;
   logic [CHAN_W-1:0]   master_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [CHAN_W-1:0]   floor_ff;
   logic [CHAN_W-1:0]   peak_ff;
   logic [COLOR_W-1:0]  color_ff, color_in;

   // Working values of one request.
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [PERIOD_W-1:0]  phase_ff, phase_in;
   logic [CHAN_W-1:0]    eff_ff, eff_in;
   logic [CHAN_W-1:0]    bright_ff, bright_in;
   logic [COLOR_W-1:0]   grb_ff, grb_in;

   logic                 accept;
   logic [PERIOD_W-2:0]  half;
   logic                 half_zero;
   logic [CHAN_W-1:0]    lo;
   logic [CHAN_W-1:0]    span;
   logic                 rising;
   logic [PERIOD_W-1:0]  ramp_pos;
   logic [CHAN_W-1:0]    chan_val;

   logic                 mul_start, mul_done;
   logic [CHAN_W-1:0]    mul_a;
   logic [PERIOD_W-1:0]  mul_b;
   logic [PROD_W-1:0]    mul_prod;
   logic [CHAN_W-1:0]    mul_scaled;

   logic                 div_start, div_done;
   logic [ELAPSED_W-1:0] div_dvd;
   logic [PERIOD_W-1:0]  div_dvs;
   logic [ELAPSED_W-1:0] div_quo;
   logic [PERIOD_W-1:0]  div_rem;

   logic                 tx_start, tx_done;

   assign req.ready = state_ff == ST_IDLE;
   assign accept    = req.valid && req.ready;

   // Breath wave terms; a floor above the peak collapses onto the peak.
   assign half      = period_ff[PERIOD_W-1:1];
   assign half_zero = half == '0;
   assign lo        = (floor_ff > peak_ff) ? peak_ff : floor_ff;
   assign span      = peak_ff - lo;
   assign rising    = phase_ff < {1'b0, half};
   assign ramp_pos  = rising ? phase_ff : phase_ff - {1'b0, half};

   // Channels are scaled in transmit order: green, red, blue.
   always_comb begin
      case (ch_ff)
         2'd0:    chan_val = color_ff[2*CHAN_W-1:CHAN_W];
         2'd1:    chan_val = color_ff[3*CHAN_W-1:2*CHAN_W];
         default: chan_val = color_ff[CHAN_W-1:0];
      endcase
   end

   // Operand selection for the shared serial units.
   always_comb begin
      case (state_ff)
         ST_RAMP_MUL: begin
            mul_a = span;
            mul_b = ramp_pos;
         end
         ST_EFF_MUL: begin
            mul_a = eff_ff;
            mul_b = {{(PERIOD_W-CHAN_W){1'b0}}, master_ff};
         end
         default: begin
            mul_a = chan_val;
            mul_b = {{(PERIOD_W-CHAN_W){1'b0}}, bright_ff};
         end
      endcase
   end

   assign div_dvd = (state_ff == ST_MOD) ? elapsed_ff
                                         : {{(ELAPSED_W-PROD_W){1'b0}}, mul_prod};
   assign div_dvs = (state_ff == ST_MOD) ? period_ff : {1'b0, half};

   assign mul_start = kick_ff && (state_ff == ST_RAMP_MUL || state_ff == ST_EFF_MUL
                                  || state_ff == ST_CHAN);
   assign div_start = kick_ff && (state_ff == ST_MOD || state_ff == ST_RAMP_DIV);
   assign tx_start  = kick_ff && (state_ff == ST_SEND);

   assign mul_scaled = div255(mul_prod[2*CHAN_W-1:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.req_type)
                  REQ_SET, REQ_REFRESH: state_in = ST_CHAN;
                  REQ_CLEAR:            state_in = ST_SEND;
                  default:              state_in = half_zero ? ST_IDLE : ST_MOD;
               endcase
            end
         end
         ST_MOD:      if (div_done) state_in = ST_RAMP_MUL;
         ST_RAMP_MUL: if (mul_done) state_in = ST_RAMP_DIV;
         ST_RAMP_DIV: if (div_done) state_in = ST_EFF_MUL;
         ST_EFF_MUL:  if (mul_done) state_in = ST_CHAN;
         ST_CHAN:     if (mul_done && ch_ff == CH_LAST) state_in = ST_SEND;
         ST_SEND:     if (tx_done) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath updates and the start pulse for the next unit.
   always_comb begin
      kick_in    = 1'b0;
      ch_in      = ch_ff;
      color_in   = color_ff;
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      eff_in     = eff_ff;
      bright_in  = bright_ff;
      grb_in     = grb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.req_type)
                  REQ_SET: begin
                     color_in  = {req.red_in, req.green_in, req.blue_in};
                     bright_in = master_ff;
                     ch_in     = '0;
                     kick_in   = 1'b1;
                  end
                  REQ_REFRESH: begin
                     bright_in = master_ff;
                     ch_in     = '0;
                     kick_in   = 1'b1;
                  end
                  REQ_CLEAR: begin
                     grb_in  = '0;
                     kick_in = 1'b1;
                  end
                  default: begin
                     elapsed_in = req.millis_in;
                     kick_in    = !half_zero;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (div_done) begin
               phase_in = div_rem;
               kick_in  = 1'b1;
            end
         end
         ST_RAMP_MUL: begin
            kick_in = mul_done;
         end
         ST_RAMP_DIV: begin
            if (div_done) begin
               // The ramp quotient never exceeds the span, so eight bits suffice.
               eff_in  = rising ? lo + div_quo[CHAN_W-1:0] : peak_ff - div_quo[CHAN_W-1:0];
               kick_in = 1'b1;
            end
         end
         ST_EFF_MUL: begin
            if (mul_done) begin
               bright_in = mul_scaled;
               ch_in     = '0;
               kick_in   = 1'b1;
            end
         end
         ST_CHAN: begin
            if (mul_done) begin
               grb_in  = {grb_ff[2*CHAN_W-1:0], mul_scaled};
               ch_in   = ch_ff + 1'b1;
               kick_in = 1'b1;
            end
         end
         default: begin
            kick_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         kick_ff   <= 1'b0;
         ch_ff     <= '0;
         color_ff  <= COLOR_RESET;
         master_ff <= MASTER_RESET;
         period_ff <= PERIOD_RESET;
         floor_ff  <= FLOOR_RESET;
         peak_ff   <= PEAK_RESET;
      end else begin
         state_ff <= state_in;
         kick_ff  <= kick_in;
         ch_ff    <= ch_in;
         color_ff <= color_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MASTER: master_ff <= csr_wdata[CHAN_W-1:0];
               CSR_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
               CSR_FLOOR:  floor_ff  <= csr_wdata[CHAN_W-1:0];
               CSR_PEAK:   peak_ff   <= csr_wdata[CHAN_W-1:0];
               default:    master_ff <= master_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      phase_ff   <= phase_in;
      eff_ff     <= eff_in;
      bright_ff  <= bright_in;
      grb_ff     <= grb_in;
   end

   rlpe_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mult_a  (mul_a),
      .mult_b  (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   rlpe_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   rlpe_symbol_tx u_tx (
      .clock (clock),
      .reset (reset),
      .start (tx_start),
      .grb   (grb_ff),
      .done  (tx_done),
      .rsp   (rsp)
   );

   // Symbols appear only while a frame is being sent.
   `RLPE_ASSERT_NOW(a_rsp_only_in_send, clock, reset, rsp.valid,
                    state_ff == ST_SEND, "symbol outside send phase")
   // A new request never overlaps a frame still on the output.
   `RLPE_ASSERT_NOW(a_no_overlap, clock, reset, req.valid && req.ready,
                    !rsp.valid, "request taken during frame")
   // Once the reset symbol has gone, the core is idle again.
   `RLPE_ASSERT_NEXT(a_idle_after_frame, clock, reset,
                     rsp.valid && rsp.ready && rsp.last_symbol,
                     state_ff == ST_IDLE, "not idle after frame end")
   // Each start pulse lasts a single cycle.
   `RLPE_ASSERT_NEXT(a_kick_single, clock, reset, kick_ff, !kick_ff, "start pulse held")

endmodule
